>>> rtl/akfs_pkg.sv
package akfs_pkg;

  typedef logic [15:0] word_t;
  typedef word_t [15:0] cols_t;
  typedef word_t [23:0] addr_terms_t;
  typedef logic [24:0] [31:0] pair_bits_t;
  typedef word_t [24:0] pair_masks_t;

  typedef struct packed {
    logic        direction;
    logic [15:0] key_word;
    logic        region_kind;
    logic [31:0] region_base;
    logic [15:0] scramble_start;
  } akfs_cfg_t;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth = 32;

  localparam logic [CfgIndexWidth-1:0] REG_DIRECTION      = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_KEY_WORD       = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_REGION_KIND    = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_REGION_BASE    = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_SCRAMBLE_START = 3'd4;

  localparam logic DIR_DECRYPT = 1'b0;
  localparam logic DIR_ENCRYPT = 1'b1;
  localparam logic REGION_MCU  = 1'b0;
  localparam logic REGION_PPM  = 1'b1;

  localparam logic [31:0] REGION_BASE_RESET    = 32'h0100_0000;
  localparam logic [15:0] SCRAMBLE_START_RESET = 16'h0084;

  localparam cols_t MIX_COLS = {
    16'hA908, 16'h5221, 16'h2908, 16'h1000, 16'h0900, 16'hAD1A, 16'h1220, 16'h0100,
    16'h52A1, 16'hFFFF, 16'h1020, 16'hA918, 16'h0908, 16'h52A5, 16'hA91A, 16'h1221
  };

  localparam addr_terms_t ADDR_TERMS = {
    16'hEFDF, 16'h0000, 16'hA818, 16'h5B21, 16'hB93A, 16'h56E7, 16'hA91A, 16'h4084,
    16'h5221, 16'h8432, 16'h0000, 16'hEE9F, 16'h5080, 16'hDFF7, 16'hEFDF, 16'h4285,
    16'hCBB1, 16'h52A5, 16'h14C4, 16'hA71B, 16'hD6F7, 16'hC99F, 16'h3E7F, 16'h0FAE
  };

  localparam pair_bits_t PAIR_BITS = {
    32'h0080_0000, 32'h0008_0100, 32'h0004_4000, 32'h0004_0040, 32'h0002_0200,
    32'h0001_0400, 32'h0001_0040, 32'h0001_0010, 32'h0000_A000, 32'h0000_9000,
    32'h0000_8008, 32'h0000_4040, 32'h0000_4010, 32'h0000_2080, 32'h0000_2020,
    32'h0000_1100, 32'h0000_1080, 32'h0000_1020, 32'h0000_0900, 32'h0000_0840,
    32'h0000_0810, 32'h0000_0600, 32'h0000_0480, 32'h0000_0220, 32'h0000_0140
  };

  localparam pair_masks_t PAIR_MASKS = {
    16'hB908, 16'hA918, 16'h1B20, 16'hA91A, 16'h53A5,
    16'h0908, 16'h5221, 16'hAD1A, 16'hBD3A, 16'h1000,
    16'h2908, 16'hA908, 16'hA91A, 16'hFBBD, 16'h0100,
    16'h52A1, 16'h0908, 16'h1221, 16'h2008, 16'h1220,
    16'h5221, 16'hB928, 16'h1221, 16'h52A1, 16'h1000
  };

  // Gauss-Jordan over GF(2); evaluated at elaboration only.
  function automatic cols_t invert_mix(input cols_t cols);
    cols_t img;
    cols_t pre;
    word_t tmp;
    int    k_sel;
    logic  found;
    for (int k = 0; k < 16; k++) begin
      img[k] = cols[k];
      pre[k] = word_t'(1) << k;
    end
    for (int p = 0; p < 16; p++) begin
      found = 1'b0;
      k_sel = p;
      for (int k = p; k < 16; k++) begin
        if (!found && img[k][p]) begin
          found = 1'b1;
          k_sel = k;
        end
      end
      if (found) begin
        if (k_sel != p) begin
          tmp = img[k_sel]; img[k_sel] = img[p]; img[p] = tmp;
          tmp = pre[k_sel]; pre[k_sel] = pre[p]; pre[p] = tmp;
        end
        for (int r = 0; r < 16; r++) begin
          if (r != p && img[r][p]) begin
            img[r] = img[r] ^ img[p];
            pre[r] = pre[r] ^ pre[p];
          end
        end
      end
    end
    return pre;
  endfunction

  localparam cols_t MIX_INV = invert_mix(MIX_COLS);

  function automatic word_t apply_cols(input cols_t cols, input word_t x);
    word_t r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) begin
        r = r ^ cols[i];
      end
    end
    return r;
  endfunction

  function automatic word_t addr_mask(input logic [31:0] a);
    word_t m;
    m = '0;
    for (int i = 0; i < 25; i++) begin
      if ((a & PAIR_BITS[i]) == PAIR_BITS[i]) begin
        m = m ^ PAIR_MASKS[i];
      end
    end
    for (int i = 0; i < 24; i++) begin
      if (a[i+1]) begin
        m = m ^ ADDR_TERMS[i];
      end
    end
    return m;
  endfunction

endpackage

>>> rtl/address_keyed_flash_word_scrambler.sv
// Channel  Handshake                 Payload
// in       in_valid / in_ready       word_address[31:0], data_in[15:0], end_of_block
// out      out_valid / out_ready     data_out[15:0], end_of_block_out
// cfg      cfg_write (no wait)       cfg_index[2:0], cfg_data[31:0]
//
// One transaction per cycle while the output is not stalled; data passes an input register, then a result register.
// Mask and GF(2) mix are one XOR tree between the two registers.
// rst clears config registers to reset values and empties both stages.
// Output stall holds the result; the input stage keeps accepting until both stages fill.
module address_keyed_flash_word_scrambler
  import akfs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [31:0]              word_address,
  input  logic [15:0]              data_in,
  input  logic                     end_of_block,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [15:0]              data_out,
  output logic                     end_of_block_out,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  akfs_cfg_t   cfg;
  logic        s1_valid;
  logic [31:0] s1_address;
  logic [15:0] s1_data;
  logic        s1_eob;
  logic [15:0] data_out_next;
  logic        s2_load;
  logic        s1_load;

  assign s2_load  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_load;
  assign s1_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction      <= DIR_DECRYPT;
      cfg.key_word       <= '0;
      cfg.region_kind    <= REGION_MCU;
      cfg.region_base    <= REGION_BASE_RESET;
      cfg.scramble_start <= SCRAMBLE_START_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DIRECTION:      cfg.direction      <= cfg_data[0];
        REG_KEY_WORD:       cfg.key_word       <= cfg_data[15:0];
        REG_REGION_KIND:    cfg.region_kind    <= cfg_data[0];
        REG_REGION_BASE:    cfg.region_base    <= cfg_data[31:0];
        REG_SCRAMBLE_START: cfg.scramble_start <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_address <= word_address;
      s1_data    <= data_in;
      s1_eob     <= end_of_block;
    end
  end

  akfs_core u_core (
    .cfg          (cfg),
    .word_address (s1_address),
    .data_in      (s1_data),
    .data_out     (data_out_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      data_out         <= data_out_next;
      end_of_block_out <= s1_eob;
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result stage");

  a_eob_follows: assert property (@(posedge clk) disable iff (rst)
    s2_load && s1_valid |=> end_of_block_out == $past(s1_eob))
    else $error("block end mark lost");

  a_clear_prefix: assert property (@(posedge clk) disable iff (rst)
    s2_load && s1_valid && cfg.region_kind == REGION_MCU
      && (s1_address - cfg.region_base) < {16'b0, cfg.scramble_start}
    |=> data_out == $past(s1_data))
    else $error("clear prefix word was modified");

  a_valid_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_load |=> out_valid)
    else $error("stage one transaction dropped");
`endif

endmodule

>>> rtl/akfs_core.sv
module akfs_core
  import akfs_pkg::*;
(
  input  akfs_cfg_t   cfg,
  input  logic [31:0] word_address,
  input  logic [15:0] data_in,
  output logic [15:0] data_out
);

  logic [31:0] offset;
  logic        scrambled;
  word_t       mask;
  word_t       dec_word;
  word_t       enc_word;

  assign offset    = word_address - cfg.region_base;
  assign scrambled = (cfg.region_kind == REGION_PPM) || (offset >= {16'b0, cfg.scramble_start});
  assign mask      = addr_mask(word_address);
  assign dec_word  = apply_cols(MIX_INV, data_in ^ mask) ^ cfg.key_word;
  assign enc_word  = apply_cols(MIX_COLS, data_in ^ cfg.key_word) ^ mask;

  always_comb begin
    if (!scrambled) begin
      data_out = data_in;
    end else if (cfg.direction == DIR_ENCRYPT) begin
      data_out = enc_word;
    end else begin
      data_out = dec_word;
    end
  end

endmodule

>>> tb/sv/tb.sv
module tb
  import akfs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RegCount = 5;
  localparam int PhaseCount = 10;
  localparam int WordsPerPhase = 75;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    word_t data;
    logic  eob;
  } flash_word_t;

  typedef struct packed {
    logic        dir;
    logic        kind;
    logic [31:0] addr;
    word_t       data;
    logic        eob;
    logic        typed;
    word_t       want;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [31:0]              word_address = '0;
  logic [15:0]              data_in = '0;
  logic                     end_of_block = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [15:0]              data_out;
  logic                     end_of_block_out;
  logic                     cfg_write = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;

  word_t mix_col [16] = '{
    16'h1221, 16'hA91A, 16'h52A5, 16'h0908, 16'hA918, 16'h1020, 16'hFFFF, 16'h52A1,
    16'h0100, 16'h1220, 16'hAD1A, 16'h0900, 16'h1000, 16'h2908, 16'h5221, 16'hA908
  };

  word_t addr_bit_term [24] = '{
    16'h0FAE, 16'h3E7F, 16'hC99F, 16'hD6F7, 16'hA71B, 16'h14C4, 16'h52A5, 16'hCBB1,
    16'h4285, 16'hEFDF, 16'hDFF7, 16'h5080, 16'hEE9F, 16'h0000, 16'h8432, 16'h5221,
    16'h4084, 16'hA91A, 16'h56E7, 16'hB93A, 16'h5B21, 16'hA818, 16'h0000, 16'hEFDF
  };

  logic [31:0] pair_sel_bits [25] = '{
    32'h0000_0140, 32'h0000_0220, 32'h0000_0480, 32'h0000_0600, 32'h0000_0810,
    32'h0000_0840, 32'h0000_0900, 32'h0000_1020, 32'h0000_1080, 32'h0000_1100,
    32'h0000_2020, 32'h0000_2080, 32'h0000_4010, 32'h0000_4040, 32'h0000_8008,
    32'h0000_9000, 32'h0000_A000, 32'h0001_0010, 32'h0001_0040, 32'h0001_0400,
    32'h0002_0200, 32'h0004_0040, 32'h0004_4000, 32'h0008_0100, 32'h0080_0000
  };

  word_t pair_term_val [25] = '{
    16'h1000, 16'h52A1, 16'h1221, 16'hB928, 16'h5221,
    16'h1220, 16'h2008, 16'h1221, 16'h0908, 16'h52A1,
    16'h0100, 16'hFBBD, 16'hA91A, 16'hA908, 16'h2908,
    16'h1000, 16'hBD3A, 16'hAD1A, 16'h5221, 16'h0908,
    16'h53A5, 16'hA91A, 16'h1B20, 16'hA918, 16'hB908
  };

  stim_row_t stim_rows [22] = '{
    '{DIR_DECRYPT, REGION_MCU, 32'h0100_0000, 16'hBEEF, 1'b1, 1'b1, 16'hBEEF},
    '{DIR_DECRYPT, REGION_MCU, 32'h0100_0083, 16'h1234, 1'b0, 1'b1, 16'h1234},
    '{DIR_DECRYPT, REGION_MCU, 32'h0100_0084, 16'h1234, 1'b0, 1'b0, 16'h0000},
    '{DIR_DECRYPT, REGION_MCU, 32'h0000_0000, 16'h0000, 1'b0, 1'b1, 16'h0000},
    '{DIR_DECRYPT, REGION_MCU, 32'h0000_0000, 16'hFFFF, 1'b1, 1'b1, 16'h0040},
    '{DIR_DECRYPT, REGION_MCU, 32'h00FF_FFFF, 16'hFFFF, 1'b1, 1'b0, 16'h0000},
    '{DIR_DECRYPT, REGION_MCU, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{DIR_DECRYPT, REGION_MCU, 32'hFE00_0001, 16'hA5A5, 1'b0, 1'b0, 16'h0000},
    '{DIR_DECRYPT, REGION_MCU, 32'h0080_0000, 16'h0000, 1'b1, 1'b0, 16'h0000},
    '{DIR_DECRYPT, REGION_MCU, 32'h0000_0140, 16'h5555, 1'b0, 1'b0, 16'h0000},
    '{DIR_DECRYPT, REGION_MCU, 32'h0000_A000, 16'hAAAA, 1'b0, 1'b0, 16'h0000},
    '{DIR_DECRYPT, REGION_MCU, 32'h0004_4000, 16'h0F0F, 1'b1, 1'b0, 16'h0000},
    '{DIR_DECRYPT, REGION_MCU, 32'h01FF_FFFE, 16'h0001, 1'b0, 1'b0, 16'h0000},
    '{DIR_DECRYPT, REGION_PPM, 32'h0100_0000, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{DIR_DECRYPT, REGION_PPM, 32'h0100_0001, 16'hFFFF, 1'b1, 1'b0, 16'h0000},
    '{DIR_ENCRYPT, REGION_PPM, 32'h0000_0000, 16'h0000, 1'b0, 1'b1, 16'h0000},
    '{DIR_ENCRYPT, REGION_PPM, 32'h0000_0000, 16'h0001, 1'b0, 1'b1, 16'h1221},
    '{DIR_ENCRYPT, REGION_PPM, 32'h0000_0000, 16'h8000, 1'b1, 1'b1, 16'hA908},
    '{DIR_ENCRYPT, REGION_MCU, 32'h0100_0010, 16'hCAFE, 1'b0, 1'b1, 16'hCAFE},
    '{DIR_ENCRYPT, REGION_MCU, 32'h0100_0084, 16'hCAFE, 1'b1, 1'b0, 16'h0000},
    '{DIR_ENCRYPT, REGION_MCU, 32'h0000_FFFE, 16'h0F0F, 1'b0, 1'b0, 16'h0000},
    '{DIR_ENCRYPT, REGION_MCU, 32'h00FF_FFFE, 16'hFFFF, 1'b1, 1'b0, 16'h0000}
  };

  word_t       unmix_lut [65536];
  akfs_cfg_t   cfg_mirror;
  flash_word_t expected_q [$];
  bit          bursts_on = 1'b1;
  int          err_count = 0;
  int          words_sent = 0;
  int          results_checked = 0;
  int          settings_applied = 0;
  int          cycle_count = 0;

  address_keyed_flash_word_scrambler dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .word_address     (word_address),
    .data_in          (data_in),
    .end_of_block     (end_of_block),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .data_out         (data_out),
    .end_of_block_out (end_of_block_out),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic word_t mix_word(input word_t x);
    word_t acc;
    acc = '0;
    for (int k = 0; k < 16; k++) begin
      if (x[k]) begin
        acc ^= mix_col[k];
      end
    end
    return acc;
  endfunction

  function automatic word_t addr_scramble_mask(input logic [31:0] a);
    word_t acc;
    acc = '0;
    for (int i = 0; i < 25; i++) begin
      if ((a & pair_sel_bits[i]) == pair_sel_bits[i]) begin
        acc ^= pair_term_val[i];
      end
    end
    for (int i = 0; i < 24; i++) begin
      if (a[i+1]) begin
        acc ^= addr_bit_term[i];
      end
    end
    return acc;
  endfunction

  function automatic flash_word_t predict_word(input logic [31:0] a, input word_t d,
                                               input logic eob);
    flash_word_t res;
    logic [31:0] offset;
    offset = a - cfg_mirror.region_base;
    res.data = d;
    res.eob = eob;
    if (cfg_mirror.region_kind == REGION_PPM || offset >= {16'h0, cfg_mirror.scramble_start})
    begin
      if (cfg_mirror.direction == DIR_DECRYPT) begin
        res.data = unmix_lut[d ^ addr_scramble_mask(a)] ^ cfg_mirror.key_word;
      end else begin
        res.data = mix_word(d ^ cfg_mirror.key_word) ^ addr_scramble_mask(a);
      end
    end
    return res;
  endfunction

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_DIRECTION:      cfg_mirror.direction = val[0];
      REG_KEY_WORD:       cfg_mirror.key_word = val[15:0];
      REG_REGION_KIND:    cfg_mirror.region_kind = val[0];
      REG_REGION_BASE:    cfg_mirror.region_base = val;
      REG_SCRAMBLE_START: cfg_mirror.scramble_start = val[15:0];
      default: ;
    endcase
  endtask

  // upper bits carry noise that the block must drop
  task automatic apply_settings(input logic dir, input word_t key, input logic kind,
                                input logic [31:0] base, input word_t start);
    logic [31:0] noise;
    noise = $urandom();
    write_reg(REG_DIRECTION, {noise[31:1], dir});
    noise = $urandom();
    write_reg(REG_KEY_WORD, {noise[31:16], key});
    write_reg(CfgIndexWidth'(RegCount + $urandom_range(0, 2)), $urandom());
    noise = $urandom();
    write_reg(REG_REGION_KIND, {noise[31:1], kind});
    write_reg(REG_REGION_BASE, base);
    noise = $urandom();
    write_reg(REG_SCRAMBLE_START, {noise[31:16], start});
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  task automatic send_word(input logic [31:0] addr, input word_t data, input logic eob,
                           input logic typed, input word_t want);
    flash_word_t exp_word;
    bit          taken;
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    word_address <= addr;
    data_in      <= data;
    end_of_block <= eob;
    exp_word = predict_word(addr, data, eob);
    if (typed) begin
      exp_word.data = want;
    end
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (in_ready === 1'b1);
      @(posedge clk);
    end
    expected_q.push_back(exp_word);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (bursts_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(negedge clk) begin : check_results
    flash_word_t exp_word;
    if (rst === 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transaction: data_out %h end_of_block_out %b",
               data_out, end_of_block_out);
        err_count++;
      end else begin
        exp_word = expected_q.pop_front();
        results_checked++;
        if (data_out !== exp_word.data) begin
          $error("data_out: expected %h, actual %h", exp_word.data, data_out);
          err_count++;
        end
        if (end_of_block_out !== exp_word.eob) begin
          $error("end_of_block_out: expected %b, actual %b", exp_word.eob, end_of_block_out);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic        dir;
    logic        kind;
    word_t       key;
    logic [31:0] base;
    word_t       start;
    logic [31:0] addr;
    int          pick;

    for (int x = 0; x < 65536; x++) begin
      unmix_lut[mix_word(word_t'(x))] = word_t'(x);
    end
    cfg_mirror = '{direction: DIR_DECRYPT, key_word: 16'h0000, region_kind: REGION_MCU,
                   region_base: REGION_BASE_RESET, scramble_start: SCRAMBLE_START_RESET};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].dir != cfg_mirror.direction ||
          stim_rows[i].kind != cfg_mirror.region_kind) begin
        drain_results();
        apply_settings(stim_rows[i].dir, cfg_mirror.key_word, stim_rows[i].kind,
                       cfg_mirror.region_base, cfg_mirror.scramble_start);
      end
      send_word(stim_rows[i].addr, stim_rows[i].data, stim_rows[i].eob,
                stim_rows[i].typed, stim_rows[i].want);
    end

    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain_results();
      dir   = logic'($urandom_range(0, 1));
      kind  = ($urandom_range(0, 3) == 0) ? REGION_PPM : REGION_MCU;
      key   = word_t'($urandom());
      base  = $urandom();
      start = $urandom_range(0, 1) ? word_t'($urandom()) : word_t'($urandom_range(0, 512));
      case (ph)
        0: begin
          dir = DIR_DECRYPT; kind = REGION_MCU;
          key = 16'hFFFF; base = 32'h0000_0000; start = 16'hFFFF;
        end
        1: begin
          dir = DIR_ENCRYPT; kind = REGION_MCU;
          key = 16'h0000; base = 32'hFFFF_FFFF; start = 16'h0000;
        end
        2: begin
          dir = DIR_DECRYPT; kind = REGION_PPM;
        end
        3: begin
          dir = DIR_ENCRYPT; kind = REGION_PPM;
        end
        default: ;
      endcase
      apply_settings(dir, key, kind, base, start);
      bursts_on = (ph != PhaseCount - 1);
      for (int n = 0; n < WordsPerPhase; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          addr = cfg_mirror.region_base +
                 $urandom_range(0, 2 * cfg_mirror.scramble_start + 64);
        end else if (pick == 5) begin
          addr = cfg_mirror.region_base - $urandom_range(1, 256);
        end else begin
          addr = $urandom();
        end
        send_word(addr, word_t'($urandom()), logic'($urandom_range(0, 1)), 1'b0, 16'h0000);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d flash words across %0d register settings; %0d results compared.",
             words_sent, settings_applied, results_checked);
    $display("Both directions, both region kinds, clear prefix and wrapped offsets exercised.");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
